// ----- rtl/core/qte_pkg.sv -----
// Shared constants, types and functions of the quaternion to Euler angle converter.
`timescale 1ns / 1ps

package qte_pkg;

    localparam int CORDIC_STAGES_DEFAULT = 16;
    localparam int XY_W = 40;
    localparam int Z_W = 36;
    localparam int OUT_W = 38;
    localparam int NUM_W = 33;
    localparam int MAG_W = 31;
    localparam int DIV_REM_W = 34;
    localparam int SQ_W = 62;
    localparam int DIV_STEPS = 31;
    localparam int SQRT_STEPS = 31;
    localparam int PREP_LAT = DIV_STEPS + SQRT_STEPS + 2;

    localparam logic signed [Z_W-1:0] PI_Q30 = 36'sd3373259426;
    localparam logic signed [Z_W-1:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic [MAG_W-1:0] MAG_ONE = 31'h40000000;
    localparam logic [SQ_W-1:0] ONE_Q60 = 62'h1000000000000000;
    localparam logic [15:0] MARGIN_RESET = 16'd27;

    typedef enum logic [1:0] {
        CASE_REGULAR  = 2'd0,
        CASE_POS_LOCK = 2'd1,
        CASE_NEG_LOCK = 2'd2
    } sing_case_t;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [NUM_W-1:0] norm;
        logic             zero_norm;
        logic             t2_neg;
        sing_case_t       mode;
        logic [XY_W-1:0]  yaw_x;
        logic [XY_W-1:0]  yaw_y;
        logic [XY_W-1:0]  roll_x;
        logic [XY_W-1:0]  roll_y;
    } front_t;

    function automatic logic [29:0] atan_q30(input logic [4:0] idx);
        logic [29:0] v;
        case (idx)
            5'd0:  v = 30'h3243F6A8;
            5'd1:  v = 30'h1DAC6705;
            5'd2:  v = 30'h0FADBAFC;
            5'd3:  v = 30'h07F56EA6;
            5'd4:  v = 30'h03FEAB76;
            5'd5:  v = 30'h01FFD55B;
            5'd6:  v = 30'h00FFFAAA;
            5'd7:  v = 30'h007FFF55;
            5'd8:  v = 30'h003FFFEA;
            5'd9:  v = 30'h001FFFFD;
            5'd10: v = 30'h000FFFFF;
            5'd11: v = 30'h0007FFFF;
            5'd12: v = 30'h0003FFFF;
            5'd13: v = 30'h0001FFFF;
            5'd14: v = 30'h0000FFFF;
            5'd15: v = 30'h00007FFF;
            5'd16: v = 30'h00003FFF;
            5'd17: v = 30'h00001FFF;
            5'd18: v = 30'h00000FFF;
            5'd19: v = 30'h000007FF;
            5'd20: v = 30'h000003FF;
            5'd21: v = 30'h000001FF;
            5'd22: v = 30'h000000FF;
            5'd23: v = 30'h0000007F;
            5'd24: v = 30'h0000003F;
            5'd25: v = 30'h0000001F;
            5'd26: v = 30'h0000000F;
            5'd27: v = 30'h00000008;
            5'd28: v = 30'h00000004;
            5'd29: v = 30'h00000002;
            5'd30: v = 30'h00000001;
            default: v = 30'h00000000;
        endcase
        return v;
    endfunction

    // Rounds a Q.30 angle half up to Q3.13 and saturates it.
    function automatic logic [15:0] q313_sat(input logic signed [OUT_W-1:0] v);
        logic signed [OUT_W-1:0] r;
        r = (v + 38'sd65536) >>> 17;
        if (r > 38'sd32767) begin
            return 16'h7FFF;
        end
        if (r < -38'sd32768) begin
            return 16'h8000;
        end
        return r[15:0];
    endfunction

endpackage

// ----- rtl/core/quaternion_to_euler.sv -----
// Top level of the quaternion to Euler angle converter.
//
//  Channel   Direction  Signals                       Content
//  config    in         cfg_we, cfg_wdata[15:0]       singular_margin
//  s_axis    in         s_tvalid, s_tready, s_tdata   quaternion, Q2.14
//  m_axis    out        m_tvalid, m_tready, m_tdata,  yaw, pitch, roll Q3.13,
//                       m_tuser                       singular_case
//
// One transfer per cycle in each direction while the input is not stalled; the pipelined
// divider, square and root stages run ahead of the three CORDICs.
// Reset clears all valid bits and sets singular_margin to 27.
// A two-entry output buffer takes results while m_tready is low; s_tready drops
// only when both entries are full, and the whole pipeline then holds.
`timescale 1ns / 1ps

module quaternion_to_euler #(
    parameter int CORDIC_STAGES = qte_pkg::CORDIC_STAGES_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // quat_w, quat_x, quat_y, quat_z
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // yaw_angle, pitch_angle, roll_angle
    output logic [1:0]  m_tuser    // singular_case
);

    localparam int XW = qte_pkg::XY_W;
    localparam int SIDE_W = 1 + 4 * XW;

    logic [15:0]         margin_reg;
    logic                ce;
    logic                f_valid, p_valid;
    qte_pkg::front_t     f_data;
    logic [qte_pkg::MAG_W-1:0] p_mag, p_root;
    logic [SIDE_W-1:0]   side_d, side_q;
    logic [1:0]          mode_q;
    qte_pkg::sing_case_t mode;
    logic                t2_neg_d;
    logic [XW-1:0]       yaw_x_d, yaw_y_d, roll_x_d, roll_y_d;
    logic [XW-1:0]       pitch_x, pitch_y;
    logic signed [XW-1:0] mag_s;
    logic                yaw_v, pitch_v, roll_v, pipe_v;
    logic [qte_pkg::Z_W-1:0] yaw_z, pitch_z, roll_z;
    logic signed [qte_pkg::OUT_W-1:0] yaw_w, pitch_w;
    logic [47:0]         res_data;
    logic [1:0]          res_user;

    logic        m_valid_reg, skid_v_reg;
    logic [47:0] m_data_reg, skid_data_reg;
    logic [1:0]  m_user_reg, skid_user_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            margin_reg <= qte_pkg::MARGIN_RESET;
        end
        else if (cfg_we)
        begin
            margin_reg <= cfg_wdata;
        end
    end

    assign ce       = !skid_v_reg;
    assign s_tready = ce;

    qte_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (s_tvalid),
        .quat_w    ($signed(s_tdata[15:0])),
        .quat_x    ($signed(s_tdata[31:16])),
        .quat_y    ($signed(s_tdata[47:32])),
        .quat_z    ($signed(s_tdata[63:48])),
        .margin    (margin_reg),
        .out_valid (f_valid),
        .out_data  (f_data)
    );

    qte_asin_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (f_valid),
        .num       (f_data.num),
        .norm      (f_data.norm),
        .zero_norm (f_data.zero_norm),
        .out_valid (p_valid),
        .mag       (p_mag),
        .root      (p_root)
    );

    assign side_d = {f_data.t2_neg, f_data.yaw_x, f_data.yaw_y, f_data.roll_x, f_data.roll_y};

    qte_delay #(
        .W     (SIDE_W),
        .DEPTH (qte_pkg::PREP_LAT)
    ) u_side_dly (
        .clk (clk),
        .ce  (ce),
        .d   (side_d),
        .q   (side_q)
    );

    qte_delay #(
        .W     (2),
        .DEPTH (qte_pkg::PREP_LAT + CORDIC_STAGES + 1)
    ) u_mode_dly (
        .clk (clk),
        .ce  (ce),
        .d   (f_data.mode),
        .q   (mode_q)
    );

    assign {t2_neg_d, yaw_x_d, yaw_y_d, roll_x_d, roll_y_d} = side_q;
    assign mode    = qte_pkg::sing_case_t'(mode_q);
    assign mag_s   = $signed({{(XW-qte_pkg::MAG_W){1'b0}}, p_mag});
    assign pitch_y = t2_neg_d ? -mag_s : mag_s;
    assign pitch_x = {{(XW-qte_pkg::MAG_W){1'b0}}, p_root};

    qte_cordic #(.STAGES(CORDIC_STAGES)) u_yaw (
        .clk (clk), .rst_n (rst_n), .ce (ce), .in_valid (p_valid),
        .in_x (yaw_x_d), .in_y (yaw_y_d), .out_valid (yaw_v), .out_z (yaw_z)
    );

    qte_cordic #(.STAGES(CORDIC_STAGES)) u_pitch (
        .clk (clk), .rst_n (rst_n), .ce (ce), .in_valid (p_valid),
        .in_x (pitch_x), .in_y (pitch_y), .out_valid (pitch_v), .out_z (pitch_z)
    );

    qte_cordic #(.STAGES(CORDIC_STAGES)) u_roll (
        .clk (clk), .rst_n (rst_n), .ce (ce), .in_valid (p_valid),
        .in_x (roll_x_d), .in_y (roll_y_d), .out_valid (roll_v), .out_z (roll_z)
    );

    assign pipe_v = yaw_v & pitch_v & roll_v;

    always_comb
    begin
        case (mode)
            qte_pkg::CASE_POS_LOCK:
            begin
                yaw_w   = qte_pkg::OUT_W'($signed(yaw_z)) <<< 1;
                pitch_w = qte_pkg::OUT_W'(qte_pkg::HALF_PI_Q30);
            end
            qte_pkg::CASE_NEG_LOCK:
            begin
                yaw_w   = -(qte_pkg::OUT_W'($signed(yaw_z)) <<< 1);
                pitch_w = -qte_pkg::OUT_W'(qte_pkg::HALF_PI_Q30);
            end
            default:
            begin
                yaw_w   = qte_pkg::OUT_W'($signed(yaw_z));
                pitch_w = qte_pkg::OUT_W'($signed(pitch_z));
            end
        endcase
        res_data[15:0]  = qte_pkg::q313_sat(yaw_w);
        res_data[31:16] = qte_pkg::q313_sat(pitch_w);
        if (mode == qte_pkg::CASE_REGULAR)
        begin
            res_data[47:32] = qte_pkg::q313_sat(qte_pkg::OUT_W'($signed(roll_z)));
        end
        else
        begin
            res_data[47:32] = 16'h0000;
        end
        res_user = mode;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            skid_v_reg  <= 1'b0;
        end
        else if (m_valid_reg && m_tready)
        begin
            if (skid_v_reg)
            begin
                skid_v_reg <= 1'b0;
            end
            else
            begin
                m_valid_reg <= ce && pipe_v;
            end
        end
        else if (!m_valid_reg)
        begin
            m_valid_reg <= ce && pipe_v;
        end
        else if (ce && pipe_v)
        begin
            skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (m_valid_reg && m_tready && skid_v_reg)
        begin
            m_data_reg <= skid_data_reg;
            m_user_reg <= skid_user_reg;
        end
        else if (!m_valid_reg || m_tready)
        begin
            m_data_reg <= res_data;
            m_user_reg <= res_user;
        end
        if (m_valid_reg && !m_tready && !skid_v_reg)
        begin
            skid_data_reg <= res_data;
            skid_user_reg <= res_user;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg |-> m_valid_reg)
        else $error("Output buffer holds a result while the output register is empty.");

    a_lock_roll_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && (m_user_reg != qte_pkg::CASE_REGULAR)) |-> (m_data_reg[47:32] == 16'h0000))
        else $error("Roll is not zero in a gimbal lock.");

    a_lock_pitch: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && (m_user_reg == qte_pkg::CASE_POS_LOCK)) |->
        (m_data_reg[31:16] == qte_pkg::q313_sat(qte_pkg::OUT_W'(qte_pkg::HALF_PI_Q30))))
        else $error("Pitch is not pi/2 in a positive gimbal lock.");

    a_full_stalls_input: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && !m_tready && skid_v_reg) |=> !s_tready)
        else $error("Input accepted while both output entries are full.");

endmodule

// ----- rtl/core/qte_delay.sv -----
// Shift line that keeps side data in step with the pipeline.
`timescale 1ns / 1ps

module qte_delay #(
    parameter int W = 8,
    parameter int DEPTH = 1
) (
    input  logic         clk,
    input  logic         ce,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] tap_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            tap_reg[0] <= d;
            for (int i = 1; i < DEPTH; i++)
            begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign q = tap_reg[DEPTH-1];

endmodule

// ----- rtl/core/qte_front.sv -----
// Product stage and the sum, lock detection and argument stage.
`timescale 1ns / 1ps

module qte_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                ce,
    input  logic                in_valid,
    input  logic signed [15:0]  quat_w,
    input  logic signed [15:0]  quat_x,
    input  logic signed [15:0]  quat_y,
    input  logic signed [15:0]  quat_z,
    input  logic [15:0]         margin,
    output logic                out_valid,
    output qte_pkg::front_t     out_data
);

    logic signed [31:0] p_ww_reg, p_xx_reg, p_yy_reg, p_zz_reg, p_wx_reg;
    logic signed [31:0] p_yz_reg, p_wz_reg, p_xy_reg, p_wy_reg, p_xz_reg;
    logic signed [15:0] w_reg, y_reg;
    logic               v1_reg, v2_reg;
    qte_pkg::front_t    f_next, f_reg;

    logic signed [33:0] norm_s, t2_s, t2_abs, dy_yaw, dx_yaw, dy_roll, dx_roll;
    logic signed [35:0] lim_s, t2_x;
    logic               pos_lock, neg_lock;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (ce)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            p_ww_reg <= quat_w * quat_w;
            p_xx_reg <= quat_x * quat_x;
            p_yy_reg <= quat_y * quat_y;
            p_zz_reg <= quat_z * quat_z;
            p_wx_reg <= quat_w * quat_x;
            p_yz_reg <= quat_y * quat_z;
            p_wz_reg <= quat_w * quat_z;
            p_xy_reg <= quat_x * quat_y;
            p_wy_reg <= quat_w * quat_y;
            p_xz_reg <= quat_x * quat_z;
            w_reg    <= quat_w;
            y_reg    <= quat_y;
            f_reg    <= f_next;
        end
    end

    always_comb
    begin
        norm_s  = 34'(p_ww_reg) + 34'(p_xx_reg) + 34'(p_yy_reg) + 34'(p_zz_reg);
        t2_s    = (34'(p_wx_reg) + 34'(p_yz_reg)) <<< 1;
        t2_abs  = (t2_s < 0) ? -t2_s : t2_s;
        lim_s   = 36'(norm_s) - $signed({19'd0, margin, 1'b0});
        t2_x    = 36'(t2_s);
        pos_lock = t2_x > lim_s;
        neg_lock = t2_x < -lim_s;
        dy_yaw  = (34'(p_wz_reg) - 34'(p_xy_reg)) <<< 1;
        dx_yaw  = 34'sd268435456 - ((34'(p_zz_reg) + 34'(p_xx_reg)) <<< 1);
        dy_roll = (34'(p_wy_reg) - 34'(p_xz_reg)) <<< 1;
        dx_roll = 34'sd268435456 - ((34'(p_yy_reg) + 34'(p_xx_reg)) <<< 1);

        f_next.num       = t2_abs[qte_pkg::NUM_W-1:0];
        f_next.norm      = norm_s[qte_pkg::NUM_W-1:0];
        f_next.zero_norm = (norm_s == 34'sd0);
        f_next.t2_neg    = t2_s < 0;
        f_next.roll_x    = qte_pkg::XY_W'(dx_roll);
        f_next.roll_y    = qte_pkg::XY_W'(dy_roll);
        if (pos_lock)
        begin
            f_next.mode  = qte_pkg::CASE_POS_LOCK;
        end
        else if (neg_lock)
        begin
            f_next.mode  = qte_pkg::CASE_NEG_LOCK;
        end
        else
        begin
            f_next.mode  = qte_pkg::CASE_REGULAR;
        end
        if (pos_lock || neg_lock)
        begin
            f_next.yaw_x = qte_pkg::XY_W'(w_reg);
            f_next.yaw_y = qte_pkg::XY_W'(y_reg);
        end
        else
        begin
            f_next.yaw_x = qte_pkg::XY_W'(dx_yaw);
            f_next.yaw_y = qte_pkg::XY_W'(dy_yaw);
        end
    end

    assign out_valid = v2_reg;
    assign out_data  = f_reg;

endmodule

// ----- rtl/core/qte_asin_prep.sv -----
// Pipelined divider, square and root that give the sine magnitude and the cosine of pitch.
`timescale 1ns / 1ps

module qte_asin_prep (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        ce,
    input  logic                        in_valid,
    input  logic [qte_pkg::NUM_W-1:0]   num,
    input  logic [qte_pkg::NUM_W-1:0]   norm,
    input  logic                        zero_norm,
    output logic                        out_valid,
    output logic [qte_pkg::MAG_W-1:0]   mag,
    output logic [qte_pkg::MAG_W-1:0]   root
);

    localparam int DN = qte_pkg::DIV_STEPS;
    localparam int SN = qte_pkg::SQRT_STEPS;

    logic [qte_pkg::DIV_REM_W-1:0] div_rem_reg  [DN];
    logic [qte_pkg::MAG_W-1:0]     div_q_reg    [DN];
    logic [qte_pkg::NUM_W-1:0]     div_norm_reg [DN];
    logic                          div_zero_reg [DN];
    logic                          div_v_reg    [DN];

    logic [qte_pkg::MAG_W-1:0] mag_c;
    logic [qte_pkg::SQ_W-1:0]  sq_next;
    logic [qte_pkg::SQ_W-1:0]  mul_sq_reg, sub_v_reg;
    logic [qte_pkg::MAG_W-1:0] mul_mag_reg, sub_mag_reg;
    logic                      mul_v_reg, sub_v_valid_reg;

    logic [qte_pkg::SQ_W-1:0]  sq_rem_reg  [SN];
    logic [qte_pkg::SQ_W-1:0]  sq_root_reg [SN];
    logic [qte_pkg::MAG_W-1:0] sq_mag_reg  [SN];
    logic                      sq_v_reg    [SN];

    for (genvar k = 0; k < DN; k++)
    begin : g_div
        logic [qte_pkg::DIV_REM_W-1:0] cand;
        logic [qte_pkg::NUM_W-1:0]     nrm;
        logic [qte_pkg::MAG_W-1:0]     qp;
        logic                          zin;
        logic                          vin;
        logic                          ge;
        if (k == 0)
        begin : g_first
            assign cand = {1'b0, num};
            assign nrm  = norm;
            assign qp   = '0;
            assign zin  = zero_norm;
            assign vin  = in_valid;
        end
        else
        begin : g_next
            assign cand = {div_rem_reg[k-1][qte_pkg::DIV_REM_W-2:0], 1'b0};
            assign nrm  = div_norm_reg[k-1];
            assign qp   = div_q_reg[k-1];
            assign zin  = div_zero_reg[k-1];
            assign vin  = div_v_reg[k-1];
        end
        assign ge = cand >= {1'b0, nrm};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                div_v_reg[k] <= 1'b0;
            end
            else if (ce)
            begin
                div_v_reg[k] <= vin;
            end
        end

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                div_rem_reg[k]  <= ge ? (cand - {1'b0, nrm}) : cand;
                div_q_reg[k]    <= {qp[qte_pkg::MAG_W-2:0], ge};
                div_norm_reg[k] <= nrm;
                div_zero_reg[k] <= zin;
            end
        end
    end

    always_comb
    begin
        if (div_zero_reg[DN-1])
        begin
            mag_c = '0;
        end
        else if (div_q_reg[DN-1] > qte_pkg::MAG_ONE)
        begin
            mag_c = qte_pkg::MAG_ONE;
        end
        else
        begin
            mag_c = div_q_reg[DN-1];
        end
        sq_next = mag_c * mag_c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_v_reg       <= 1'b0;
            sub_v_valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            mul_v_reg       <= div_v_reg[DN-1];
            sub_v_valid_reg <= mul_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            mul_sq_reg  <= sq_next;
            mul_mag_reg <= mag_c;
            sub_v_reg   <= qte_pkg::ONE_Q60 - mul_sq_reg;
            sub_mag_reg <= mul_mag_reg;
        end
    end

    for (genvar k = 0; k < SN; k++)
    begin : g_sqrt
        logic [qte_pkg::SQ_W-1:0]  rin;
        logic [qte_pkg::SQ_W-1:0]  oin;
        logic [qte_pkg::SQ_W-1:0]  bit_w;
        logic [qte_pkg::SQ_W-1:0]  trial;
        logic [qte_pkg::MAG_W-1:0] min;
        logic                      vin;
        logic                      ge;
        if (k == 0)
        begin : g_first
            assign rin = sub_v_reg;
            assign oin = '0;
            assign min = sub_mag_reg;
            assign vin = sub_v_valid_reg;
        end
        else
        begin : g_next
            assign rin = sq_rem_reg[k-1];
            assign oin = sq_root_reg[k-1];
            assign min = sq_mag_reg[k-1];
            assign vin = sq_v_reg[k-1];
        end
        assign bit_w = qte_pkg::SQ_W'(1) << (2 * (SN - 1 - k));
        assign trial = oin + bit_w;
        assign ge    = rin >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_v_reg[k] <= 1'b0;
            end
            else if (ce)
            begin
                sq_v_reg[k] <= vin;
            end
        end

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                sq_rem_reg[k]  <= ge ? (rin - trial) : rin;
                sq_root_reg[k] <= ge ? ((oin >> 1) + bit_w) : (oin >> 1);
                sq_mag_reg[k]  <= min;
            end
        end
    end

    assign out_valid = sq_v_reg[SN-1];
    assign mag       = sq_mag_reg[SN-1];
    assign root      = sq_root_reg[SN-1][qte_pkg::MAG_W-1:0];

endmodule

// ----- rtl/core/qte_cordic.sv -----
// Pipelined vectoring CORDIC that gives atan2(y, x) in Q.30 radians.
`timescale 1ns / 1ps

module qte_cordic #(
    parameter int STAGES = qte_pkg::CORDIC_STAGES_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       ce,
    input  logic                       in_valid,
    input  logic [qte_pkg::XY_W-1:0]   in_x,
    input  logic [qte_pkg::XY_W-1:0]   in_y,
    output logic                       out_valid,
    output logic [qte_pkg::Z_W-1:0]    out_z
);

    logic signed [qte_pkg::XY_W-1:0] sx, sy;
    logic signed [qte_pkg::XY_W-1:0] pre_x_reg, pre_y_reg;
    logic signed [qte_pkg::Z_W-1:0]  pre_z_reg;
    logic                            pre_zero_reg, pre_v_reg;

    logic signed [qte_pkg::XY_W-1:0] it_x_reg [STAGES];
    logic signed [qte_pkg::XY_W-1:0] it_y_reg [STAGES];
    logic signed [qte_pkg::Z_W-1:0]  it_z_reg [STAGES];
    logic                            it_zero_reg [STAGES];
    logic                            it_v_reg [STAGES];

    assign sx = $signed(in_x);
    assign sy = $signed(in_y);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_v_reg <= 1'b0;
        end
        else if (ce)
        begin
            pre_v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            pre_zero_reg <= (sx == 0) && (sy == 0);
            if (sx < 0)
            begin
                pre_x_reg <= -sx;
                pre_y_reg <= -sy;
                pre_z_reg <= (sy >= 0) ? qte_pkg::PI_Q30 : -qte_pkg::PI_Q30;
            end
            else
            begin
                pre_x_reg <= sx;
                pre_y_reg <= sy;
                pre_z_reg <= '0;
            end
        end
    end

    for (genvar i = 0; i < STAGES; i++)
    begin : g_iter
        logic signed [qte_pkg::XY_W-1:0] xin, yin, dx, dy;
        logic signed [qte_pkg::Z_W-1:0]  zin, ang;
        logic                            zr, vin;
        if (i == 0)
        begin : g_first
            assign xin = pre_x_reg;
            assign yin = pre_y_reg;
            assign zin = pre_z_reg;
            assign zr  = pre_zero_reg;
            assign vin = pre_v_reg;
        end
        else
        begin : g_next
            assign xin = it_x_reg[i-1];
            assign yin = it_y_reg[i-1];
            assign zin = it_z_reg[i-1];
            assign zr  = it_zero_reg[i-1];
            assign vin = it_v_reg[i-1];
        end
        assign dx  = yin >>> i;
        assign dy  = xin >>> i;
        assign ang = $signed({{(qte_pkg::Z_W-30){1'b0}}, qte_pkg::atan_q30(5'(i))});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                it_v_reg[i] <= 1'b0;
            end
            else if (ce)
            begin
                it_v_reg[i] <= vin;
            end
        end

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                it_zero_reg[i] <= zr;
                if (yin > 0)
                begin
                    it_x_reg[i] <= xin + dx;
                    it_y_reg[i] <= yin - dy;
                    it_z_reg[i] <= zin + ang;
                end
                else
                begin
                    it_x_reg[i] <= xin - dx;
                    it_y_reg[i] <= yin + dy;
                    it_z_reg[i] <= zin - ang;
                end
            end
        end
    end

    assign out_valid = it_v_reg[STAGES-1];
    assign out_z     = it_zero_reg[STAGES-1] ? '0 : it_z_reg[STAGES-1];

endmodule

// ----- tb/quaternion_to_euler_checker.sv -----
// Checker that predicts and compares every result of the quaternion to Euler converter.
`timescale 1ns / 1ps

module quaternion_to_euler_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,
    input  logic [1:0]  m_tuser,
    output int          fail_count,
    output int          pending
);

    localparam int STAGES = qte_pkg::CORDIC_STAGES_DEFAULT;

    typedef struct {
        logic [15:0]         yaw;
        logic [15:0]         pitch;
        logic [15:0]         roll;
        qte_pkg::sing_case_t kind;
    } angles_t;

    localparam longint ATAN_Q30 [32] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
        64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
        64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
        64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
        64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
        64'h00000001, 64'h00000000
    };
    localparam longint PI_ANGLE = 64'd3373259426;
    localparam longint HALF_PI_ANGLE = 64'd1686629713;
    localparam longint UNIT_Q28 = 64'sd1 << 28;

    logic [15:0] margin;
    angles_t     expected_angles[$];

    function automatic longint vector_angle(input longint vy, input longint vx);
        longint acc;
        longint dx;
        longint dy;
        acc = 0;
        if (vx == 0 && vy == 0)
        begin
            return 0;
        end
        if (vx < 0)
        begin
            acc = (vy >= 0) ? PI_ANGLE : -PI_ANGLE;
            vx = -vx;
            vy = -vy;
        end
        for (int i = 0; i < STAGES; i++)
        begin
            dx = vy >>> i;
            dy = vx >>> i;
            if (vy > 0)
            begin
                vx += dx;
                vy -= dy;
                acc += ATAN_Q30[i];
            end
            else
            begin
                vx -= dx;
                vy += dy;
                acc -= ATAN_Q30[i];
            end
        end
        return acc;
    endfunction

    function automatic logic [15:0] round_q313(input longint a);
        longint r;
        r = (a + 65536) >>> 17;
        if (r > 32767)
        begin
            r = 32767;
        end
        if (r < -32768)
        begin
            r = -32768;
        end
        return r[15:0];
    endfunction

    function automatic longint unsigned floor_root(input longint unsigned v);
        longint unsigned res;
        longint unsigned trial;
        res = 0;
        for (int k = 31; k >= 0; k--)
        begin
            trial = res | (64'd1 << k);
            if (trial * trial <= v)
            begin
                res = trial;
            end
        end
        return res;
    endfunction

    function automatic angles_t euler_from_quat(input logic [63:0] q, input logic [15:0] mg);
        angles_t          a;
        longint           w;
        longint           x;
        longint           y;
        longint           z;
        longint           norm;
        longint           t2;
        longint           lim;
        longint           r;
        longint unsigned  num;
        longint unsigned  mag;
        longint unsigned  c;
        w = longint'($signed(q[15:0]));
        x = longint'($signed(q[31:16]));
        y = longint'($signed(q[47:32]));
        z = longint'($signed(q[63:48]));
        norm = w * w + x * x + y * y + z * z;
        t2 = 2 * (w * x + y * z);
        lim = norm - 2 * longint'(mg);
        if (t2 > lim)
        begin
            a.yaw = round_q313(2 * vector_angle(y, w));
            a.pitch = round_q313(HALF_PI_ANGLE);
            a.roll = '0;
            a.kind = qte_pkg::CASE_POS_LOCK;
        end
        else if (t2 < -lim)
        begin
            a.yaw = round_q313(-2 * vector_angle(y, w));
            a.pitch = round_q313(-HALF_PI_ANGLE);
            a.roll = '0;
            a.kind = qte_pkg::CASE_NEG_LOCK;
        end
        else
        begin
            mag = 0;
            if (norm > 0)
            begin
                num = (t2 < 0) ? -t2 : t2;
                mag = (num << 30) / longint'(norm);
                if (mag > (64'd1 << 30))
                begin
                    mag = 64'd1 << 30;
                end
            end
            c = floor_root((64'd1 << 60) - mag * mag);
            r = (t2 < 0) ? -longint'(mag) : longint'(mag);
            a.yaw = round_q313(vector_angle(2 * (w * z - x * y),
                                            UNIT_Q28 - 2 * (z * z + x * x)));
            a.pitch = round_q313(vector_angle(r, longint'(c)));
            a.roll = round_q313(vector_angle(2 * (w * y - x * z),
                                             UNIT_Q28 - 2 * (y * y + x * x)));
            a.kind = qte_pkg::CASE_REGULAR;
        end
        return a;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        angles_t a;
        int      errs;
        if (!rst_n)
        begin
            margin <= qte_pkg::MARGIN_RESET;
            fail_count <= 0;
            pending <= 0;
            expected_angles.delete();
        end
        else
        begin
            errs = 0;
            if (cfg_we)
            begin
                margin <= cfg_wdata;
            end
            if (s_tvalid && s_tready)
            begin
                expected_angles.push_back(euler_from_quat(s_tdata, margin));
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_angles.size() == 0)
                begin
                    $error("Result transfer with no expectation: %h %h", m_tdata, m_tuser);
                    errs++;
                end
                else
                begin
                    a = expected_angles.pop_front();
                    if (m_tdata[15:0] !== a.yaw)
                    begin
                        $error("yaw_angle expected %h actual %h", a.yaw, m_tdata[15:0]);
                        errs++;
                    end
                    if (m_tdata[31:16] !== a.pitch)
                    begin
                        $error("pitch_angle expected %h actual %h", a.pitch, m_tdata[31:16]);
                        errs++;
                    end
                    if (m_tdata[47:32] !== a.roll)
                    begin
                        $error("roll_angle expected %h actual %h", a.roll, m_tdata[47:32]);
                        errs++;
                    end
                    if (m_tuser !== a.kind)
                    begin
                        $error("singular_case expected %0d actual %0d", a.kind, m_tuser);
                        errs++;
                    end
                end
            end
            if (errs != 0)
            begin
                fail_count <= fail_count + errs;
            end
            pending <= expected_angles.size();
        end
    end

endmodule

// ----- tb/quaternion_to_euler_test.sv -----
// Stimulus and verdict for the quaternion to Euler converter.
`timescale 1ns / 1ps

module quaternion_to_euler_test;

    localparam int LATENCY = qte_pkg::CORDIC_STAGES_DEFAULT + 68;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [1:0]  m_tuser;
    int          fail_count;
    int          pending;
    int          rx_transfers = 0;
    int          rx_hold = 0;
    bit          quiet_tx = 0;

    always #5 clk = ~clk;

    quaternion_to_euler DUT (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    quaternion_to_euler_checker checker_inst (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .fail_count(fail_count), .pending(pending)
    );

    // The receiver stalls at random, runs without stalls in some stretches, and holds
    // off once for a long time so that the pipeline fills and stalls its input.
    always @(posedge clk)
    begin
        int wait_cycles;
        if (rst_n)
        begin
            if (rx_hold > 0)
            begin
                rx_hold <= rx_hold - 1;
                if (rx_hold == 1)
                begin
                    m_tready <= 1'b1;
                end
            end
            else if (m_tready && m_tvalid)
            begin
                rx_transfers <= rx_transfers + 1;
                wait_cycles = ((rx_transfers / 100) % 4 == 1) ? 0 : $urandom_range(0, 6);
                if (rx_transfers == 450)
                begin
                    wait_cycles = 400;
                end
                if (wait_cycles > 0)
                begin
                    m_tready <= 1'b0;
                    rx_hold <= wait_cycles;
                end
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_quat(input logic [15:0] w, input logic [15:0] x,
                             input logic [15:0] y, input logic [15:0] z);
        int gap;
        gap = quiet_tx ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {z, y, x, w};
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (LATENCY + 16) @(posedge clk);
    endtask

    task automatic write_margin(input logic [15:0] v);
        drain_results();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_random(input int count);
        logic [15:0] a;
        logic [15:0] d;
        int          shape;
        for (int n = 0; n < count; n++)
        begin
            quiet_tx = ((n / 60) % 3 == 2);
            shape = $urandom_range(0, 9);
            if (shape < 5)
            begin
                send_quat(16'($urandom_range(0, 32767) - 16384),
                          16'($urandom_range(0, 32767) - 16384),
                          16'($urandom_range(0, 32767) - 16384),
                          16'($urandom_range(0, 32767) - 16384));
            end
            else if (shape < 8)
            begin
                // Near gimbal lock: w close to plus or minus x, y and z tiny.
                a = 16'($urandom_range(0, 23170));
                d = 16'($urandom_range(0, 6) - 3);
                send_quat($urandom_range(0, 1) ? a : -a,
                          $urandom_range(0, 1) ? a + d : -(a + d),
                          16'($urandom_range(0, 8) - 4), 16'($urandom_range(0, 8) - 4));
            end
            else
            begin
                send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
            end
        end
        quiet_tx = 0;
    endtask

    initial
    begin
        #3000000;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_quat(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_quat(16'h4000, 16'h0000, 16'h0000, 16'h0000);
        send_quat(16'hC000, 16'h0000, 16'h0000, 16'h0000);
        send_quat(16'h0000, 16'h4000, 16'h0000, 16'h0000);
        send_quat(16'h0000, 16'h0000, 16'h4000, 16'h0000);
        send_quat(16'h0000, 16'h0000, 16'h0000, 16'h4000);
        send_quat(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_quat(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
        send_quat(16'h8000, 16'h7FFF, 16'h0001, 16'hFFFF);
        send_quat(16'd11585, 16'd11585, 16'h0000, 16'h0000);
        send_quat(16'd11585, -16'd11585, 16'h0000, 16'h0000);
        send_quat(16'd11585, 16'd11585, 16'h0100, 16'h0100);
        send_quat(-16'd11585, 16'd11585, -16'h0100, 16'h0100);
        send_quat(16'h0000, 16'h0000, 16'h4000, 16'h4000);
        send_quat(16'h0000, 16'h0000, 16'h4000, 16'hC000);
        send_quat(16'h0000, 16'h0000, 16'h8000, 16'h0000);
        send_quat(16'h0000, 16'h0000, 16'h7FFF, 16'h0000);
        send_quat(16'h0001, 16'h0000, 16'h0000, 16'h0000);
        send_quat(16'hFFFF, 16'h0001, 16'h0000, 16'h0000);
        send_quat(16'h2000, 16'h2000, 16'h2000, 16'h2000);

        send_random(300);
        drain_results();
        send_random(100);

        write_margin(16'd0);
        send_random(200);
        write_margin(16'hFFFF);
        send_quat(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_quat(16'h0040, 16'h0000, 16'h0010, 16'h0000);
        send_random(200);
        write_margin(16'd1000);
        send_random(150);
        write_margin(16'd27);
        send_random(180);

        drain_results();
        if (fail_count == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
